// ===== design/vfjq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfjq_pkg
// Shared types and constants of the voice frame jitter queue: field widths,
// register reset values, event codes, controller states and datapath commands.
// ----------------------------------------------------------------------------
package vfjq_pkg;

    // Default sizes of the queue
    localparam int QUEUE_DEPTH_DEF = 64;
    localparam int MAX_SKIP_DEF    = 8;

    // Field widths
    localparam int CFG_W    = 7;
    localparam int HANDLE_W = 16;
    localparam int LENGTH_W = 10;
    localparam int SEQ_W    = 32;

    // Configuration register resets and decode
    localparam logic [CFG_W-1:0] QUEUE_MAX_RST = 7'd16;
    localparam logic [CFG_W-1:0] QUEUE_MIN_RST = 7'd2;
    localparam logic             REG_QUEUE_MAX = 1'b0;
    localparam logic             REG_QUEUE_MIN = 1'b1;

    // Saturation value of the head drop count
    localparam logic [CFG_W-1:0] DROPS_SAT = 7'd127;

    // Input action codes
    localparam logic ACTION_ARRIVAL = 1'b0;
    localparam logic ACTION_TICK    = 1'b1;

    // Result event codes
    typedef enum logic [1:0] {
        EV_ACCEPTED = 2'd0,
        EV_DROPPED  = 2'd1,
        EV_PLAYED   = 2'd2,
        EV_IDLE     = 2'd3
    } event_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_FILL,
        ST_TRIM,
        ST_PLAY
    } state_t;

    // Datapath commands
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_PUSH_MARK,
        OP_PUSH_FRAME,
        OP_TRIM,
        OP_FETCH,
        OP_PLAY,
        OP_END_DROP,
        OP_END_IDLE,
        OP_END_MISS
    } dp_op_t;

    // Datapath status towards the controller
    typedef struct packed {
        logic is_tick;
        logic diff_neg;
        logic skip_zero;
        logic play_on;
        logic count_zero;
    } dp_status_t;

    // One queue entry
    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [LENGTH_W-1:0] length;
    } entry_t;

endpackage

// ===== design/vfjq_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfjq_ctrl
// Sequencer of the jitter queue: takes an item, steps the datapath through
// gap fill, frame write and head trim, or through a playout fetch.
// ----------------------------------------------------------------------------
module vfjq_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  vfjq_pkg::dp_status_t   status,
    output vfjq_pkg::dp_op_t       op,
    output logic                   busy
);
    import vfjq_pkg::*;

    state_t state_reg;
    state_t state_next;

    // Hold the current state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                priority if (status.is_tick)
                begin
                    if (status.play_on && !status.count_zero)
                    begin
                        state_next = ST_PLAY;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else if (status.diff_neg)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_FILL;
                end
            end
            ST_FILL:
            begin
                if (status.skip_zero)
                begin
                    state_next = ST_TRIM;
                end
            end
            ST_TRIM:
            begin
                state_next = ST_IDLE;
            end
            ST_PLAY:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Commands to the datapath
    always_comb
    begin
        op   = OP_NONE;
        busy = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    op = OP_LOAD;
                end
            end
            ST_DECIDE:
            begin
                priority if (status.is_tick)
                begin
                    priority if (!status.play_on)
                    begin
                        op = OP_END_IDLE;
                    end
                    else if (status.count_zero)
                    begin
                        op = OP_END_MISS;
                    end
                    else
                    begin
                        op = OP_FETCH;
                    end
                end
                else if (status.diff_neg)
                begin
                    op = OP_END_DROP;
                end
                else
                begin
                    op = OP_NONE;
                end
            end
            ST_FILL:
            begin
                op = status.skip_zero ? OP_PUSH_FRAME : OP_PUSH_MARK;
            end
            ST_TRIM:
            begin
                op = OP_TRIM;
            end
            ST_PLAY:
            begin
                op = OP_PLAY;
            end
            default:
            begin
                op = OP_NONE;
            end
        endcase
    end

endmodule

// ===== design/vfjq_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfjq_dp
// Datapath of the jitter queue: entry memory, head and tail pointers, fill
// count, expected sequence, playout flag and the registered result.
// ----------------------------------------------------------------------------
module vfjq_dp #(
    parameter int QUEUE_DEPTH = vfjq_pkg::QUEUE_DEPTH_DEF,
    parameter int MAX_SKIP    = vfjq_pkg::MAX_SKIP_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  vfjq_pkg::dp_op_t                    op,
    output vfjq_pkg::dp_status_t                status,
    input  logic [vfjq_pkg::CFG_W-1:0]          queue_max,
    input  logic [vfjq_pkg::CFG_W-1:0]          queue_min,
    input  logic                                action,
    input  logic signed [vfjq_pkg::SEQ_W-1:0]   seq_number,
    input  logic [vfjq_pkg::HANDLE_W-1:0]       frame_handle,
    input  logic [vfjq_pkg::LENGTH_W-1:0]       frame_length,
    output logic                                done,
    output logic [1:0]                          event_status,
    output logic [vfjq_pkg::CFG_W-1:0]          queued_count,
    output logic [vfjq_pkg::CFG_W-1:0]          heads_dropped,
    output logic                                playing,
    output logic                                play_missing,
    output logic [vfjq_pkg::HANDLE_W-1:0]       play_handle,
    output logic [vfjq_pkg::LENGTH_W-1:0]       play_length,
    output logic                                queue_drained
);
    import vfjq_pkg::*;

    localparam int AW     = $clog2(QUEUE_DEPTH);
    localparam int CW     = $clog2(QUEUE_DEPTH + 1);
    localparam int CMP_W  = (CW > CFG_W) ? CW : CFG_W;
    localparam int SUM_W  = CW + 1;
    localparam int DSUM_W = CMP_W + 1;
    localparam int KW     = $clog2(MAX_SKIP + 2);

    // Entry memory, reset undefined
    entry_t mem [QUEUE_DEPTH];
    entry_t rd_data_reg;

    // Control state
    logic [AW-1:0]    head_reg,     head_next;
    logic [AW-1:0]    tail_reg,     tail_next;
    logic [CW-1:0]    count_reg,    count_next;
    logic [SEQ_W-1:0] expected_reg, expected_next;
    logic             play_on_reg,  play_on_next;
    logic [CFG_W-1:0] drops_reg,    drops_next;
    logic             done_reg,     done_next;

    // Item held while it is worked on
    logic                action_reg,   action_next;
    logic                diff_neg_reg, diff_neg_next;
    logic [KW-1:0]       skip_reg,     skip_next;
    logic [HANDLE_W-1:0] handle_reg,   handle_next;
    logic [LENGTH_W-1:0] length_reg,   length_next;

    // Result registers
    event_t              status_reg,   status_next;
    logic [CFG_W-1:0]    qcount_reg,   qcount_next;
    logic [CFG_W-1:0]    hdrop_reg,    hdrop_next;
    logic                playing_reg,  playing_next;
    logic                missing_reg,  missing_next;
    logic [HANDLE_W-1:0] phandle_reg,  phandle_next;
    logic [LENGTH_W-1:0] plength_reg,  plength_next;
    logic                drained_reg,  drained_next;

    // Working signals
    logic [SEQ_W-1:0]  diff;
    logic              full;
    logic              push_en;
    entry_t            push_entry;
    logic [AW-1:0]     head_inc;
    logic [AW-1:0]     tail_inc;
    logic [CMP_W-1:0]  limit;
    logic [CMP_W-1:0]  excess;
    logic [SUM_W-1:0]  head_sum;
    logic [SUM_W-1:0]  head_wrap;
    logic [DSUM_W-1:0] drop_sum;
    logic [CFG_W-1:0]  drops_trim;
    logic [CW-1:0]     count_trim;

    // Sequence gap and pointer steps
    always_comb
    begin
        diff     = $unsigned(seq_number) - expected_reg;
        full     = (count_reg == CW'(QUEUE_DEPTH));
        head_inc = (head_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
        tail_inc = (tail_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
    end

    // Head trim against the saturated limit
    always_comb
    begin
        limit = (CMP_W'(queue_max) > CMP_W'(QUEUE_DEPTH)) ? CMP_W'(QUEUE_DEPTH)
                                                          : CMP_W'(queue_max);
        excess = (CMP_W'(count_reg) > limit) ? CMP_W'(count_reg) - limit : '0;
        head_sum  = SUM_W'(head_reg) + SUM_W'(excess);
        head_wrap = (head_sum >= SUM_W'(QUEUE_DEPTH)) ? head_sum - SUM_W'(QUEUE_DEPTH)
                                                      : head_sum;
        drop_sum   = DSUM_W'(drops_reg) + DSUM_W'(excess);
        drops_trim = (drop_sum > DSUM_W'(DROPS_SAT)) ? DROPS_SAT : CFG_W'(drop_sum);
        count_trim = CW'(CMP_W'(count_reg) - excess);
    end

    // Entry to write
    always_comb
    begin
        push_en = (op == OP_PUSH_MARK) || (op == OP_PUSH_FRAME);
        if (op == OP_PUSH_FRAME)
        begin
            push_entry.handle = handle_reg;
            push_entry.length = length_reg;
        end
        else
        begin
            push_entry.handle = '0;
            push_entry.length = '0;
        end
    end

    // Next values
    always_comb
    begin
        head_next     = head_reg;
        tail_next     = tail_reg;
        count_next    = count_reg;
        expected_next = expected_reg;
        play_on_next  = play_on_reg;
        drops_next    = drops_reg;
        done_next     = 1'b0;
        action_next   = action_reg;
        diff_neg_next = diff_neg_reg;
        skip_next     = skip_reg;
        handle_next   = handle_reg;
        length_next   = length_reg;
        status_next   = status_reg;
        qcount_next   = qcount_reg;
        hdrop_next    = hdrop_reg;
        playing_next  = playing_reg;
        missing_next  = missing_reg;
        phandle_next  = phandle_reg;
        plength_next  = plength_reg;
        drained_next  = drained_reg;

        unique case (op)
            OP_LOAD:
            begin
                action_next   = action;
                diff_neg_next = diff[SEQ_W-1];
                skip_next     = (diff > SEQ_W'(MAX_SKIP)) ? KW'(MAX_SKIP) : KW'(diff);
                handle_next   = (frame_length == '0) ? '0 : frame_handle;
                length_next   = frame_length;
                drops_next    = '0;
                if (action == ACTION_ARRIVAL)
                begin
                    if (CMP_W'(count_reg) >= CMP_W'(queue_min))
                    begin
                        play_on_next = 1'b1;
                    end
                    if (!diff[SEQ_W-1])
                    begin
                        expected_next = $unsigned(seq_number) + 1'b1;
                    end
                end
            end
            OP_PUSH_MARK, OP_PUSH_FRAME:
            begin
                // Write at the tail, dropping the head when storage is full
                tail_next = tail_inc;
                if (full)
                begin
                    head_next = head_inc;
                    if (drops_reg != DROPS_SAT)
                    begin
                        drops_next = drops_reg + 1'b1;
                    end
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                end
                if (op == OP_PUSH_MARK)
                begin
                    skip_next = skip_reg - 1'b1;
                end
            end
            OP_TRIM:
            begin
                head_next    = AW'(head_wrap);
                count_next   = count_trim;
                drops_next   = drops_trim;
                done_next    = 1'b1;
                status_next  = EV_ACCEPTED;
                qcount_next  = CFG_W'(count_trim);
                hdrop_next   = drops_trim;
                playing_next = play_on_reg;
                missing_next = 1'b0;
                phandle_next = '0;
                plength_next = '0;
                drained_next = 1'b0;
            end
            OP_FETCH:
            begin
            end
            OP_PLAY:
            begin
                // Dequeue the head; a real frame that empties the queue stops playout
                head_next    = head_inc;
                count_next   = count_reg - 1'b1;
                done_next    = 1'b1;
                status_next  = EV_PLAYED;
                qcount_next  = CFG_W'(count_reg - 1'b1);
                hdrop_next   = '0;
                missing_next = (rd_data_reg.length == '0);
                phandle_next = (rd_data_reg.length == '0) ? '0 : rd_data_reg.handle;
                plength_next = rd_data_reg.length;
                drained_next = (rd_data_reg.length != '0) && (count_reg == CW'(1));
                if ((rd_data_reg.length != '0) && (count_reg == CW'(1)))
                begin
                    play_on_next = 1'b0;
                end
                playing_next = !((rd_data_reg.length != '0) && (count_reg == CW'(1)));
            end
            OP_END_DROP, OP_END_IDLE, OP_END_MISS:
            begin
                done_next    = 1'b1;
                qcount_next  = CFG_W'(count_reg);
                hdrop_next   = '0;
                playing_next = play_on_reg;
                missing_next = (op == OP_END_MISS);
                phandle_next = '0;
                plength_next = '0;
                drained_next = 1'b0;
                priority if (op == OP_END_DROP)
                begin
                    status_next = EV_DROPPED;
                end
                else if (op == OP_END_IDLE)
                begin
                    status_next = EV_IDLE;
                end
                else
                begin
                    status_next = EV_PLAYED;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg     <= '0;
            tail_reg     <= '0;
            count_reg    <= '0;
            expected_reg <= '0;
            play_on_reg  <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            count_reg    <= count_next;
            expected_reg <= expected_next;
            play_on_reg  <= play_on_next;
            done_reg     <= done_next;
        end
    end

    // Item and result registers
    always_ff @(posedge clk)
    begin
        drops_reg    <= drops_next;
        action_reg   <= action_next;
        diff_neg_reg <= diff_neg_next;
        skip_reg     <= skip_next;
        handle_reg   <= handle_next;
        length_reg   <= length_next;
        status_reg   <= status_next;
        qcount_reg   <= qcount_next;
        hdrop_reg    <= hdrop_next;
        playing_reg  <= playing_next;
        missing_reg  <= missing_next;
        phandle_reg  <= phandle_next;
        plength_reg  <= plength_next;
        drained_reg  <= drained_next;
    end

    // Entry memory: write at the tail, registered read at the head
    always_ff @(posedge clk)
    begin
        if (push_en)
        begin
            mem[tail_reg] <= push_entry;
        end
        if (op == OP_FETCH)
        begin
            rd_data_reg <= mem[head_reg];
        end
    end

    // Status to the controller
    always_comb
    begin
        status.is_tick    = (action_reg == ACTION_TICK);
        status.diff_neg   = diff_neg_reg;
        status.skip_zero  = (skip_reg == '0);
        status.play_on    = play_on_reg;
        status.count_zero = (count_reg == '0);
    end

    // Result ports
    assign done          = done_reg;
    assign event_status  = status_reg;
    assign queued_count  = qcount_reg;
    assign heads_dropped = hdrop_reg;
    assign playing       = playing_reg;
    assign play_missing  = missing_reg;
    assign play_handle   = phandle_reg;
    assign play_length   = plength_reg;
    assign queue_drained = drained_reg;

    // Fill count stays within storage
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("fill count beyond storage depth");

    // A trim leaves no more than the limit
    a_trim_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (op == OP_TRIM) |=> (CMP_W'(count_reg) <= $past(limit)))
        else $error("queue above limit after trim");

    // Results never come in two adjacent cycles
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe held for two cycles");

    // A drained queue stops playout
    a_drain_stop: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && drained_reg) |-> (!playing_reg && !play_on_reg && (count_reg == '0)))
        else $error("playout still on after drain");

endmodule

// ===== design/voice_frame_jitter_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voice_frame_jitter_queue
// Playout queue for sequenced voice frames with gap markers and head trim.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on start while busy is low: action 0 is a frame arrival
//   (seq_number, frame_handle, frame_length), action 1 a playout tick.
//   Each item gives one result, shown for one cycle with done high; the
//   receiver cannot hold it off. A new item may start in the done cycle.
//   An arrival writes skip gap markers, then the frame, then trims the
//     head; skip is the gap to the expected number capped at MAX_SKIP
//     (one memory write a cycle for markers and the frame). A late
//     arrival is dropped without a write; a tick that plays an entry
//     reads it through the registered read port of the entry memory.
//   Items are handled one at a time. queue_max (byte address 0) and
//   queue_min (byte address 4) are to be written over the APB port while
//   the block is idle; the block does not enforce this. pready is always
//   high. Reset empties the queue, clears the expected sequence and playout
//   and restores both registers; entry memory contents are left as they are.
// ----------------------------------------------------------------------------
module voice_frame_jitter_queue #(
    parameter int QUEUE_DEPTH = vfjq_pkg::QUEUE_DEPTH_DEF,
    parameter int MAX_SKIP    = vfjq_pkg::MAX_SKIP_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [2:0]                          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    input  logic                                start,
    output logic                                busy,
    input  logic                                action,
    input  logic signed [vfjq_pkg::SEQ_W-1:0]   seq_number,
    input  logic [vfjq_pkg::HANDLE_W-1:0]       frame_handle,
    input  logic [vfjq_pkg::LENGTH_W-1:0]       frame_length,
    output logic                                done,
    output logic [1:0]                          event_status,
    output logic [vfjq_pkg::CFG_W-1:0]          queued_count,
    output logic [vfjq_pkg::CFG_W-1:0]          heads_dropped,
    output logic                                playing,
    output logic                                play_missing,
    output logic [vfjq_pkg::HANDLE_W-1:0]       play_handle,
    output logic [vfjq_pkg::LENGTH_W-1:0]       play_length,
    output logic                                queue_drained
);
    import vfjq_pkg::*;

    logic [CFG_W-1:0] queue_max_reg;
    logic [CFG_W-1:0] queue_min_reg;
    logic             cfg_wr;
    dp_op_t           op;
    dp_status_t       status;

    // Configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            queue_max_reg <= QUEUE_MAX_RST;
            queue_min_reg <= QUEUE_MIN_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_QUEUE_MAX: queue_max_reg <= pwdata[CFG_W-1:0];
                REG_QUEUE_MIN: queue_min_reg <= pwdata[CFG_W-1:0];
                default:       queue_max_reg <= queue_max_reg;
            endcase
        end
    end

    // Register read-back
    always_comb
    begin
        unique case (paddr[2])
            REG_QUEUE_MAX: prdata = 32'(queue_max_reg);
            REG_QUEUE_MIN: prdata = 32'(queue_min_reg);
            default:       prdata = '0;
        endcase
    end

    vfjq_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .op     (op),
        .busy   (busy)
    );

    vfjq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .MAX_SKIP    (MAX_SKIP)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .op            (op),
        .status        (status),
        .queue_max     (queue_max_reg),
        .queue_min     (queue_min_reg),
        .action        (action),
        .seq_number    (seq_number),
        .frame_handle  (frame_handle),
        .frame_length  (frame_length),
        .done          (done),
        .event_status  (event_status),
        .queued_count  (queued_count),
        .heads_dropped (heads_dropped),
        .playing       (playing),
        .play_missing  (play_missing),
        .play_handle   (play_handle),
        .play_length   (play_length),
        .queue_drained (queue_drained)
    );

endmodule

// ===== bench/vfjq_playout_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfjq_playout_checker
// Watches the register port, the item channel and the result strobe of the
// jitter queue. Keeps its own copy of the queue contents, the expected
// sequence and the playout flag, predicts the result of every accepted item
// and compares each strobed result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module vfjq_playout_checker
    import vfjq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int MAX_SKIP    = MAX_SKIP_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic                 pready,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    input  logic                 start,
    input  logic                 busy,
    input  logic                 action,
    input  logic [SEQ_W-1:0]     seq_number,
    input  logic [HANDLE_W-1:0]  frame_handle,
    input  logic [LENGTH_W-1:0]  frame_length,
    input  logic                 done,
    input  logic [1:0]           event_status,
    input  logic [CFG_W-1:0]     queued_count,
    input  logic [CFG_W-1:0]     heads_dropped,
    input  logic                 playing,
    input  logic                 play_missing,
    input  logic [HANDLE_W-1:0]  play_handle,
    input  logic [LENGTH_W-1:0]  play_length,
    input  logic                 queue_drained,
    output int                   mismatches,
    output int                   pending
);

    typedef struct packed {
        event_t               status;
        logic [CFG_W-1:0]     count;
        logic [CFG_W-1:0]     drops;
        logic                 playing;
        logic                 missing;
        logic [HANDLE_W-1:0]  handle;
        logic [LENGTH_W-1:0]  length;
        logic                 drained;
    } playout_t;

    // Shadow of the block state
    logic [HANDLE_W-1:0] slot_handle [QUEUE_DEPTH];
    logic [LENGTH_W-1:0] slot_length [QUEUE_DEPTH];
    int                  head_ptr;
    int                  fill;
    logic [SEQ_W-1:0]    next_seq;
    logic                play_en;
    logic [CFG_W-1:0]    max_entries;
    logic [CFG_W-1:0]    min_entries;

    // Results predicted but not yet strobed, oldest first
    playout_t playout_due [$];

    task automatic report_error(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_error($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
    endtask

    // Drop the oldest entry, counting it
    task automatic discard_head(inout int shed);
        if (fill == 0)
            return;
        head_ptr = (head_ptr + 1) % QUEUE_DEPTH;
        fill--;
        if (shed < DROPS_SAT)
            shed++;
    endtask

    // Append an entry; a full store loses its head first
    task automatic store_entry(input logic [HANDLE_W-1:0] hdl,
                               input logic [LENGTH_W-1:0] len, inout int shed);
        int slot;
        if (fill >= QUEUE_DEPTH)
            discard_head(shed);
        slot = (head_ptr + fill) % QUEUE_DEPTH;
        slot_handle[slot] = (len == '0) ? '0 : hdl;
        slot_length[slot] = len;
        fill++;
    endtask

    task automatic predict_playout(input logic act, input logic [SEQ_W-1:0] seq,
                                   input logic [HANDLE_W-1:0] hdl,
                                   input logic [LENGTH_W-1:0] len,
                                   output playout_t r);
        logic [SEQ_W-1:0] gap;
        int               prior_fill;
        int               cap;
        int               skip;
        int               shed;
        r    = '0;
        shed = 0;
        if (act == ACTION_ARRIVAL) begin
            prior_fill = fill;
            gap        = seq - next_seq;
            if (gap[SEQ_W-1]) begin
                r.status = EV_DROPPED;
            end
            else begin
                cap  = (max_entries > QUEUE_DEPTH) ? QUEUE_DEPTH : int'(max_entries);
                skip = (gap > MAX_SKIP) ? MAX_SKIP : int'(gap);
                // gap markers, then the frame, then trim to the limit
                repeat (skip)
                    store_entry('0, '0, shed);
                store_entry(hdl, len, shed);
                while (fill > cap)
                    discard_head(shed);
                next_seq = seq + 1;
                r.status = EV_ACCEPTED;
            end
            if (prior_fill >= min_entries)
                play_en = 1'b1;
        end
        else if (!play_en) begin
            r.status = EV_IDLE;
        end
        else begin
            r.status = EV_PLAYED;
            if (fill == 0) begin
                r.missing = 1'b1;
            end
            else begin
                r.handle = slot_handle[head_ptr];
                r.length = slot_length[head_ptr];
                head_ptr = (head_ptr + 1) % QUEUE_DEPTH;
                fill--;
                if (r.length == '0) begin
                    r.missing = 1'b1;
                    r.handle  = '0;
                end
                else if (fill == 0) begin
                    r.drained = 1'b1;
                    play_en   = 1'b0;
                end
            end
        end
        r.count   = CFG_W'(fill);
        r.drops   = CFG_W'(shed);
        r.playing = play_en;
    endtask

    always @(posedge clk) begin
        playout_t want;
        if (!rst_n) begin
            head_ptr    = 0;
            fill        = 0;
            next_seq    = '0;
            play_en     = 1'b0;
            max_entries = QUEUE_MAX_RST;
            min_entries = QUEUE_MIN_RST;
            mismatches  = 0;
            playout_due.delete();
        end
        else begin
            // Track register writes
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == REG_QUEUE_MAX)
                    max_entries = pwdata[CFG_W-1:0];
                else
                    min_entries = pwdata[CFG_W-1:0];
            end

            // Compare a strobed result with the oldest prediction
            if ($isunknown(done)) begin
                report_error("done is unknown");
            end
            else if (done) begin
                if (playout_due.size() == 0) begin
                    report_error("result strobed with no item outstanding");
                end
                else begin
                    want = playout_due.pop_front();
                    check_field("event_status", 32'(event_status), 32'(want.status));
                    check_field("queued_count", 32'(queued_count), 32'(want.count));
                    check_field("heads_dropped", 32'(heads_dropped), 32'(want.drops));
                    check_field("playing", 32'(playing), 32'(want.playing));
                    check_field("play_missing", 32'(play_missing), 32'(want.missing));
                    check_field("play_handle", 32'(play_handle), 32'(want.handle));
                    check_field("play_length", 32'(play_length), 32'(want.length));
                    check_field("queue_drained", 32'(queue_drained), 32'(want.drained));
                end
            end

            // Predict each accepted item
            if (start && !busy) begin
                predict_playout(action, seq_number, frame_handle, frame_length, want);
                playout_due.push_back(want);
            end
        end
        pending = playout_due.size();
    end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the voice frame jitter queue: a directed run over sequence
// extremes, gaps, late frames and draining, then random phases under several
// register settings and sender idle rates. The checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
    import vfjq_pkg::*;

    localparam int          CYCLE_LIMIT    = 200000;
    localparam int          PHASE_ITEMS    = 48;
    localparam logic [2:0]  ADDR_QUEUE_MAX = {REG_QUEUE_MAX, 2'b00};
    localparam logic [2:0]  ADDR_QUEUE_MIN = {REG_QUEUE_MIN, 2'b00};

    logic                 clk;
    logic                 rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [2:0]           paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;
    logic                 start;
    logic                 busy;
    logic                 action;
    logic [SEQ_W-1:0]     seq_number;
    logic [HANDLE_W-1:0]  frame_handle;
    logic [LENGTH_W-1:0]  frame_length;
    logic                 done;
    logic [1:0]           event_status;
    logic [CFG_W-1:0]     queued_count;
    logic [CFG_W-1:0]     heads_dropped;
    logic                 playing;
    logic                 play_missing;
    logic [HANDLE_W-1:0]  play_handle;
    logic [LENGTH_W-1:0]  play_length;
    logic                 queue_drained;
    int                   mismatches;
    int                   pending;

    int unsigned          cycle_count = 0;
    int                   idle_pct;
    logic [SEQ_W-1:0]     seq_next;

    voice_frame_jitter_queue u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .start         (start),
        .busy          (busy),
        .action        (action),
        .seq_number    (seq_number),
        .frame_handle  (frame_handle),
        .frame_length  (frame_length),
        .done          (done),
        .event_status  (event_status),
        .queued_count  (queued_count),
        .heads_dropped (heads_dropped),
        .playing       (playing),
        .play_missing  (play_missing),
        .play_handle   (play_handle),
        .play_length   (play_length),
        .queue_drained (queue_drained)
    );

    vfjq_playout_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .start         (start),
        .busy          (busy),
        .action        (action),
        .seq_number    (seq_number),
        .frame_handle  (frame_handle),
        .frame_length  (frame_length),
        .done          (done),
        .event_status  (event_status),
        .queued_count  (queued_count),
        .heads_dropped (heads_dropped),
        .playing       (playing),
        .play_missing  (play_missing),
        .play_handle   (play_handle),
        .play_length   (play_length),
        .queue_drained (queue_drained),
        .mismatches    (mismatches),
        .pending       (pending)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Guard against a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Present one item, idling at random first, and hold it until accepted
    task automatic send_item(input logic act, input logic [SEQ_W-1:0] seq,
                             input logic [HANDLE_W-1:0] hdl,
                             input logic [LENGTH_W-1:0] len);
        logic [SEQ_W-1:0] gap;
        @(negedge clk);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(negedge clk);
        end
        start        <= 1'b1;
        action       <= act;
        seq_number   <= seq;
        frame_handle <= hdl;
        frame_length <= len;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        // follow the sequence the block will expect next
        gap = seq - seq_next;
        if (act == ACTION_ARRIVAL && !gap[SEQ_W-1])
            seq_next = seq + 1;
    endtask

    // Hold off until every result has come, then let the block settle
    task automatic drain_queue(input int extra);
        @(negedge clk);
        start <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (extra)
            @(negedge clk);
    endtask

    // Register write: setup cycle then access cycle
    task automatic write_reg(input logic [2:0] addr, input logic [CFG_W-1:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= ($urandom() & ~32'h7F) | 32'(val);
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Ticks and mostly in-order frames with random content; some gaps, late and wild ones
    task automatic random_item(input int tick_pct);
        logic [SEQ_W-1:0]    seq;
        logic [LENGTH_W-1:0] len;
        int                  pick;
        if ($urandom_range(99) < 2)
            drain_queue(2);
        if ($urandom_range(99) < tick_pct) begin
            send_item(ACTION_TICK, $urandom(), HANDLE_W'($urandom()),
                      LENGTH_W'($urandom()));
        end
        else begin
            pick = $urandom_range(99);
            if (pick < 55)
                seq = seq_next;
            else if (pick < 78)
                seq = seq_next + $urandom_range(1, MAX_SKIP_DEF + 2);
            else if (pick < 88)
                seq = seq_next - $urandom_range(1, 6);
            else if (pick < 93)
                seq = seq_next + $urandom_range(20, 5000);
            else
                seq = $urandom();
            pick = $urandom_range(99);
            if (pick < 15)
                len = '0;
            else if (pick < 20)
                len = '1;
            else
                len = LENGTH_W'($urandom());
            send_item(ACTION_ARRIVAL, seq, HANDLE_W'($urandom()), len);
        end
    endtask

    task automatic run_phase(input bit reprogram, input logic [CFG_W-1:0] qmax,
                             input logic [CFG_W-1:0] qmin, input int idle,
                             input int tick_pct);
        if (reprogram) begin
            drain_queue(4);
            write_reg(ADDR_QUEUE_MAX, qmax);
            write_reg(ADDR_QUEUE_MIN, qmin);
        end
        idle_pct = idle;
        repeat (PHASE_ITEMS)
            random_item(tick_pct);
    endtask

    // Stimulus
    initial
    begin
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        start        = 1'b0;
        action       = ACTION_ARRIVAL;
        seq_number   = '0;
        frame_handle = '0;
        frame_length = '0;
        seq_next     = '0;
        idle_pct     = 22;
        repeat (9)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: idle tick, sequence extremes, late frame, markers, drain
        send_item(ACTION_TICK, 32'h0, 16'h0, 10'h0);
        send_item(ACTION_ARRIVAL, 32'h7FFF_FFFF, 16'hFFFF, 10'h3FF);
        send_item(ACTION_ARRIVAL, 32'h8000_0000, 16'h1234, 10'h000);
        send_item(ACTION_ARRIVAL, 32'h7FFF_FFFE, 16'hBEEF, 10'h011);
        send_item(ACTION_ARRIVAL, 32'h8000_0003, 16'h0001, 10'h001);
        repeat (13)
            send_item(ACTION_TICK, $urandom(), HANDLE_W'($urandom()),
                      LENGTH_W'($urandom()));
        send_item(ACTION_TICK, 32'hFFFF_FFFF, 16'hFFFF, 10'h3FF);
        // wrap the sequence through all ones to zero
        send_item(ACTION_ARRIVAL, 32'hFFFF_FFFF, 16'h5555, 10'h2AA);
        send_item(ACTION_ARRIVAL, 32'h0000_0000, 16'h0000, 10'h3FF);
        send_item(ACTION_TICK, 32'h0, 16'h0, 10'h0);

        // Random phases: sender idles rarely, then often, then never
        run_phase(1'b0, QUEUE_MAX_RST, QUEUE_MIN_RST, 22, 45);
        run_phase(1'b1, 7'd0,   7'd0,   22, 45);
        run_phase(1'b1, 7'd64,  7'd64,  22, 20);
        run_phase(1'b1, 7'd127, 7'd127, 76, 20);
        run_phase(1'b1, 7'd1,   7'd0,   76, 45);
        run_phase(1'b1, 7'd8,   7'd3,   76, 40);
        run_phase(1'b1, 7'd40,  7'd10,  0,  35);
        run_phase(1'b1, 7'd64,  7'd1,   0,  30);

        drain_queue(20);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
